// File: rtl/subnet_pair_matcher_core_defines.svh
`ifndef SUBNET_PAIR_MATCHER_CORE_DEFINES_SVH
`define SUBNET_PAIR_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset
`define SPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset
`define SPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/spm_pkg.sv
`default_nettype none

package spm_pkg;

  // Command codes on the input channel
  localparam logic [1:0] OP_LOAD_SRC = 2'd0;
  localparam logic [1:0] OP_LOAD_DST = 2'd1;
  localparam logic [1:0] OP_RUN      = 2'd2;
  localparam logic [1:0] OP_IGNORE   = 2'd3;

  // Address family codes
  localparam logic [1:0] FAM_IPV4 = 2'd0;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PREFIX_W = 6;
  localparam int unsigned INDEX_W  = 3;

  localparam logic [PREFIX_W-1:0] PREFIX_MAX = PREFIX_W'(ADDR_W);

  // Controller to datapath commands
  typedef struct packed {
    logic load_src;
    logic load_dst;
    logic start;
    logic step;
    logic capture;
    logic push;
    logic finish;
  } spm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic match;
    logic last_combo;
    logic tables_empty;
    logic cand_valid;
    logic out_free;
  } spm_status_t;

  // Clamp a prefix length to the address width
  function automatic logic [PREFIX_W-1:0] sat_prefix(input logic [PREFIX_W-1:0] p);
    sat_prefix = (p > PREFIX_MAX) ? PREFIX_MAX : p;
  endfunction

  // Network mask for a clamped prefix: zero gives no bits, full width gives all
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] p);
    if (p >= PREFIX_MAX) begin
      prefix_mask = '1;
    end else begin
      prefix_mask = ~({ADDR_W{1'b1}} >> p);
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/spm_ctrl.sv
`default_nettype none

module spm_ctrl
  import spm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  spm_status_t status,
  output spm_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   advance;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take commands only when idle
  assign in_stall = (state != ST_IDLE);

  // Decode commands and walk the source/destination grid
  always_comb begin
    cmd        = '0;
    state_next = state;
    advance    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (opcode)
            OP_LOAD_SRC: cmd.load_src = 1'b1;
            OP_LOAD_DST: cmd.load_dst = 1'b1;
            OP_RUN: begin
              if (status.tables_empty) begin
                state_next = ST_FLUSH;
              end else begin
                cmd.start  = 1'b1;
                state_next = ST_SCAN;
              end
            end
            OP_IGNORE: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (status.match) begin
          if (!status.cand_valid) begin
            cmd.capture = 1'b1;
            advance     = 1'b1;
          end else if (status.out_free) begin
            cmd.push    = 1'b1;
            cmd.capture = 1'b1;
            advance     = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          cmd.step = 1'b1;
          if (status.last_combo) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/spm_dp.sv
`default_nettype none

module spm_dp
  import spm_pkg::*;
#(
  parameter int unsigned SRC_ENTRIES = 8,
  parameter int unsigned DST_ENTRIES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  spm_cmd_t            cmd,
  output spm_status_t         status,
  input  logic [1:0]          entry_family,
  input  logic [ADDR_W-1:0]   entry_address,
  input  logic [PREFIX_W-1:0] entry_prefix,
  input  logic signed [31:0]  entry_speed,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                pair_valid,
  output logic [INDEX_W-1:0]  src_index,
  output logic [INDEX_W-1:0]  dst_index,
  output logic [ADDR_W-1:0]   src_address_out,
  output logic [ADDR_W-1:0]   dst_address_out,
  output logic signed [31:0]  link_speed_out,
  output logic                overflowed,
  output logic                last
);

  localparam int unsigned SCW = $clog2(SRC_ENTRIES + 1);
  localparam int unsigned DCW = $clog2(DST_ENTRIES + 1);
  localparam int unsigned SAW = (SRC_ENTRIES > 1) ? $clog2(SRC_ENTRIES) : 1;
  localparam int unsigned DAW = (DST_ENTRIES > 1) ? $clog2(DST_ENTRIES) : 1;

  // Entry tables
  logic [1:0]          src_family_store  [SRC_ENTRIES];
  logic [ADDR_W-1:0]   src_address_store [SRC_ENTRIES];
  logic [PREFIX_W-1:0] src_prefix_store  [SRC_ENTRIES];
  logic signed [31:0]  src_speed_store   [SRC_ENTRIES];
  logic [1:0]          dst_family_store  [DST_ENTRIES];
  logic [ADDR_W-1:0]   dst_address_store [DST_ENTRIES];
  logic [PREFIX_W-1:0] dst_prefix_store  [DST_ENTRIES];
  logic signed [31:0]  dst_speed_store   [DST_ENTRIES];

  logic [SCW-1:0] src_count;
  logic [DCW-1:0] dst_count;
  logic           overflow_flag;
  logic [SCW-1:0] src_ptr;
  logic [DCW-1:0] dst_ptr;

  // Held match, waiting to learn whether it closes the run
  logic               cand_valid;
  logic [INDEX_W-1:0] cand_src_idx;
  logic [INDEX_W-1:0] cand_dst_idx;
  logic [ADDR_W-1:0]  cand_src_addr;
  logic [ADDR_W-1:0]  cand_dst_addr;
  logic signed [31:0] cand_speed;

  logic [1:0]          src_fam_cur;
  logic [1:0]          dst_fam_cur;
  logic [ADDR_W-1:0]   src_addr_cur;
  logic [ADDR_W-1:0]   dst_addr_cur;
  logic [PREFIX_W-1:0] src_pre_cur;
  logic [PREFIX_W-1:0] dst_pre_cur;
  logic signed [31:0]  src_spd_cur;
  logic signed [31:0]  dst_spd_cur;
  logic signed [31:0]  min_speed;
  logic                src_full;
  logic                dst_full;

  assign src_full = (src_count >= SCW'(SRC_ENTRIES));
  assign dst_full = (dst_count >= DCW'(DST_ENTRIES));

  // Append entries and track fill counts
  always_ff @(posedge clk) begin
    if (cmd.load_src && !src_full) begin
      src_family_store[src_count[SAW-1:0]]  <= entry_family;
      src_address_store[src_count[SAW-1:0]] <= entry_address;
      src_prefix_store[src_count[SAW-1:0]]  <= sat_prefix(entry_prefix);
      src_speed_store[src_count[SAW-1:0]]   <= entry_speed;
    end
    if (cmd.load_dst && !dst_full) begin
      dst_family_store[dst_count[DAW-1:0]]  <= entry_family;
      dst_address_store[dst_count[DAW-1:0]] <= entry_address;
      dst_prefix_store[dst_count[DAW-1:0]]  <= sat_prefix(entry_prefix);
      dst_speed_store[dst_count[DAW-1:0]]   <= entry_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_count     <= '0;
      dst_count     <= '0;
      overflow_flag <= 1'b0;
    end else if (cmd.finish) begin
      src_count     <= '0;
      dst_count     <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cmd.load_src) begin
        if (src_full) begin
          overflow_flag <= 1'b1;
        end else begin
          src_count <= src_count + SCW'(1);
        end
      end
      if (cmd.load_dst) begin
        if (dst_full) begin
          overflow_flag <= 1'b1;
        end else begin
          dst_count <= dst_count + DCW'(1);
        end
      end
    end
  end

  // Advance the grid pointers, destination fastest
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      src_ptr <= '0;
      dst_ptr <= '0;
    end else if (cmd.step) begin
      if ((dst_ptr + DCW'(1)) == dst_count) begin
        dst_ptr <= '0;
        src_ptr <= src_ptr + SCW'(1);
      end else begin
        dst_ptr <= dst_ptr + DCW'(1);
      end
    end
  end

  // Read the current pair and compare masked networks
  assign src_fam_cur  = src_family_store[src_ptr[SAW-1:0]];
  assign dst_fam_cur  = dst_family_store[dst_ptr[DAW-1:0]];
  assign src_addr_cur = src_address_store[src_ptr[SAW-1:0]];
  assign dst_addr_cur = dst_address_store[dst_ptr[DAW-1:0]];
  assign src_pre_cur  = src_prefix_store[src_ptr[SAW-1:0]];
  assign dst_pre_cur  = dst_prefix_store[dst_ptr[DAW-1:0]];
  assign src_spd_cur  = src_speed_store[src_ptr[SAW-1:0]];
  assign dst_spd_cur  = dst_speed_store[dst_ptr[DAW-1:0]];
  assign min_speed    = (src_spd_cur >= dst_spd_cur) ? dst_spd_cur : src_spd_cur;

  always_comb begin
    status.match = (src_fam_cur == FAM_IPV4) && (dst_fam_cur == FAM_IPV4) &&
                   ((src_addr_cur & prefix_mask(src_pre_cur)) ==
                    (dst_addr_cur & prefix_mask(dst_pre_cur)));
    status.last_combo   = ((dst_ptr + DCW'(1)) == dst_count) &&
                          ((src_ptr + SCW'(1)) == src_count);
    status.tables_empty = (src_count == '0) || (dst_count == '0);
    status.cand_valid   = cand_valid;
    status.out_free     = !out_valid || !out_stall;
  end

  // Hold the latest match
  always_ff @(posedge clk) begin
    if (rst || cmd.start || cmd.finish) begin
      cand_valid <= 1'b0;
    end else if (cmd.capture) begin
      cand_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cand_src_idx  <= INDEX_W'(src_ptr);
      cand_dst_idx  <= INDEX_W'(dst_ptr);
      cand_src_addr <= src_addr_cur;
      cand_dst_addr <= dst_addr_cur;
      cand_speed    <= min_speed;
    end
  end

  // Output register: drop on transfer, refill on push or finish
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || (cmd.finish && cand_valid)) begin
      pair_valid      <= 1'b1;
      src_index       <= cand_src_idx;
      dst_index       <= cand_dst_idx;
      src_address_out <= cand_src_addr;
      dst_address_out <= cand_dst_addr;
      link_speed_out  <= cand_speed;
      overflowed      <= overflow_flag;
      last            <= cmd.finish;
    end else if (cmd.finish) begin
      pair_valid      <= 1'b0;
      src_index       <= '0;
      dst_index       <= '0;
      src_address_out <= '0;
      dst_address_out <= '0;
      link_speed_out  <= '0;
      overflowed      <= overflow_flag;
      last            <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/subnet_pair_matcher_core.sv
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------------------
// in      | in_valid / in_stall  | opcode, entry_family, entry_address,
//         |                      | entry_prefix, entry_speed
// out     | out_valid / out_stall| pair_valid, src_index, dst_index, src_address_out,
//         |                      | dst_address_out, link_speed_out, overflowed, last
//
// Loads may follow each other every cycle. A run walks all S*D combinations of S
// source and D destination entries: the sequencer checks one combination per cycle
// unless a stalled output holds the walk, and skips the walk when a table is empty.
// Synchronous active-high reset empties both tables and clears the overflow flag.
// A stalled output halts the grid walk at a match while an earlier match already
// waits behind it, and holds the closing result of the run until it is free.
`default_nettype none

`include "subnet_pair_matcher_core_defines.svh"

module subnet_pair_matcher_core
  import spm_pkg::*;
#(
  parameter int unsigned SRC_ENTRIES = 8,
  parameter int unsigned DST_ENTRIES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [1:0]          entry_family,
  input  logic [ADDR_W-1:0]   entry_address,
  input  logic [PREFIX_W-1:0] entry_prefix,
  input  logic signed [31:0]  entry_speed,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                pair_valid,
  output logic [INDEX_W-1:0]  src_index,
  output logic [INDEX_W-1:0]  dst_index,
  output logic [ADDR_W-1:0]   src_address_out,
  output logic [ADDR_W-1:0]   dst_address_out,
  output logic signed [31:0]  link_speed_out,
  output logic                overflowed,
  output logic                last
);

  spm_cmd_t    cmd;
  spm_status_t status;

  spm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  spm_dp #(
    .SRC_ENTRIES (SRC_ENTRIES),
    .DST_ENTRIES (DST_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .entry_family    (entry_family),
    .entry_address   (entry_address),
    .entry_prefix    (entry_prefix),
    .entry_speed     (entry_speed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pair_valid      (pair_valid),
    .src_index       (src_index),
    .dst_index       (dst_index),
    .src_address_out (src_address_out),
    .dst_address_out (dst_address_out),
    .link_speed_out  (link_speed_out),
    .overflowed      (overflowed),
    .last            (last)
  );

  // An empty marker always closes its run
  `SPM_ASSERT_NOW(a_marker_last, out_valid && !pair_valid, last, "empty marker without last")
  // An empty marker carries zero payload
  `SPM_ASSERT_NOW(a_marker_zero, out_valid && !pair_valid,
    (src_address_out == '0) && (dst_address_out == '0) && (link_speed_out == '0),
    "empty marker with payload")
  // A run transfer blocks the input channel on the next cycle
  `SPM_ASSERT_NEXT(a_run_blocks, in_valid && !in_stall && (opcode == OP_RUN), in_stall,
    "input open right after run")

endmodule

`default_nettype wire
